// ----- rtl/ppe_pkg.sv -----
// Shared constants, types and microcode store for the perfect pairing enumerator.
`default_nettype none

package ppe_pkg;

    // Sizing
    localparam int MAX_IDX    = 16;
    localparam int POS_W      = $clog2(MAX_IDX);
    localparam int PCNT_W     = $clog2(MAX_IDX + 1);
    localparam int STK_DEPTH  = MAX_IDX / 2;
    localparam int PAIR_W     = $clog2(STK_DEPTH);
    localparam int DEPTH_W    = $clog2(STK_DEPTH + 1);
    localparam int CNT_W      = 5;
    localparam int IDX_W      = 8;
    localparam int CFG_DATA_W = 8;
    localparam int CFG_ADDR_W = 2;

    // Register indexes
    localparam logic [CFG_ADDR_W-1:0] REG_INDEX_COUNT = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_START_INDEX = 2'd1;

    // Microcode fields
    localparam int OP_W = 4;
    localparam int CC_W = 4;
    localparam int PC_W = 5;

    localparam logic [OP_W-1:0] OP_NOP      = 4'd0;
    localparam logic [OP_W-1:0] OP_ACCEPT   = 4'd1;
    localparam logic [OP_W-1:0] OP_ADV      = 4'd2;
    localparam logic [OP_W-1:0] OP_RD_SWAP  = 4'd3;
    localparam logic [OP_W-1:0] OP_WR_A     = 4'd4;
    localparam logic [OP_W-1:0] OP_WR_B     = 4'd5;
    localparam logic [OP_W-1:0] OP_WR_B_DEC = 4'd6;
    localparam logic [OP_W-1:0] OP_FILL     = 4'd7;
    localparam logic [OP_W-1:0] OP_FIN      = 4'd8;
    localparam logic [OP_W-1:0] OP_RD_PAIR  = 4'd9;
    localparam logic [OP_W-1:0] OP_EMIT     = 4'd10;
    localparam logic [OP_W-1:0] OP_SET_UNDO = 4'd11;
    localparam logic [OP_W-1:0] OP_POP      = 4'd12;
    localparam logic [OP_W-1:0] OP_END      = 4'd13;
    localparam logic [OP_W-1:0] OP_EMIT_EXH = 4'd14;

    localparam logic [CC_W-1:0] CC_NEVER      = 4'd0;
    localparam logic [CC_W-1:0] CC_ALWAYS     = 4'd1;
    localparam logic [CC_W-1:0] CC_NO_INPUT   = 4'd2;
    localparam logic [CC_W-1:0] CC_DONE       = 4'd3;
    localparam logic [CC_W-1:0] CC_NO_STEP    = 4'd4;
    localparam logic [CC_W-1:0] CC_DEPTH_LT   = 4'd5;
    localparam logic [CC_W-1:0] CC_MORE_PAIRS = 4'd6;
    localparam logic [CC_W-1:0] CC_NO_UNDO    = 4'd7;
    localparam logic [CC_W-1:0] CC_TOP_LE_REF = 4'd8;

    // Program addresses
    localparam logic [PC_W-1:0] S_IDLE  = 5'd0;
    localparam logic [PC_W-1:0] S_CHK   = 5'd1;
    localparam logic [PC_W-1:0] S_ADV   = 5'd2;
    localparam logic [PC_W-1:0] S_ASRD  = 5'd3;
    localparam logic [PC_W-1:0] S_ASW1  = 5'd4;
    localparam logic [PC_W-1:0] S_ASW2  = 5'd5;
    localparam logic [PC_W-1:0] S_FILL  = 5'd6;
    localparam logic [PC_W-1:0] S_FIN   = 5'd7;
    localparam logic [PC_W-1:0] S_EMRD  = 5'd8;
    localparam logic [PC_W-1:0] S_EMOUT = 5'd9;
    localparam logic [PC_W-1:0] S_UCHK  = 5'd10;
    localparam logic [PC_W-1:0] S_UINN  = 5'd11;
    localparam logic [PC_W-1:0] S_USRD  = 5'd12;
    localparam logic [PC_W-1:0] S_USW1  = 5'd13;
    localparam logic [PC_W-1:0] S_USW2  = 5'd14;
    localparam logic [PC_W-1:0] S_UPOP  = 5'd15;
    localparam logic [PC_W-1:0] S_END   = 5'd16;
    localparam logic [PC_W-1:0] S_EXOUT = 5'd17;

    typedef struct packed {
        logic [OP_W-1:0] op;
        logic [CC_W-1:0] cond;
        logic            hold_out;
        logic [PC_W-1:0] target;
    } t_uword;

    typedef struct packed {
        logic no_input;
        logic done;
        logic no_step;
        logic depth_lt;
        logic more_pairs;
        logic no_undo;
        logic top_le_ref;
        logic out_busy;
    } t_cond;

    function automatic t_uword make_uword(input logic [OP_W-1:0] op,
                                          input logic [CC_W-1:0] cond,
                                          input logic            hold_out,
                                          input logic [PC_W-1:0] target);
        t_uword w;
        w.op       = op;
        w.cond     = cond;
        w.hold_out = hold_out;
        w.target   = target;
        return w;
    endfunction

    // Control store: one word per step, jump to target when the condition holds
    function automatic t_uword ucode_rom(input logic [PC_W-1:0] pc);
        t_uword w;
        case (pc)
            S_IDLE:  w = make_uword(OP_ACCEPT,   CC_NO_INPUT,   1'b0, S_IDLE);
            S_CHK:   w = make_uword(OP_NOP,      CC_DONE,       1'b0, S_EXOUT);
            S_ADV:   w = make_uword(OP_ADV,      CC_NO_STEP,    1'b0, S_FILL);
            S_ASRD:  w = make_uword(OP_RD_SWAP,  CC_NEVER,      1'b0, S_IDLE);
            S_ASW1:  w = make_uword(OP_WR_A,     CC_NEVER,      1'b0, S_IDLE);
            S_ASW2:  w = make_uword(OP_WR_B,     CC_NEVER,      1'b0, S_IDLE);
            S_FILL:  w = make_uword(OP_FILL,     CC_DEPTH_LT,   1'b0, S_FILL);
            S_FIN:   w = make_uword(OP_FIN,      CC_NEVER,      1'b0, S_IDLE);
            S_EMRD:  w = make_uword(OP_RD_PAIR,  CC_NEVER,      1'b0, S_IDLE);
            S_EMOUT: w = make_uword(OP_EMIT,     CC_MORE_PAIRS, 1'b1, S_EMRD);
            S_UCHK:  w = make_uword(OP_NOP,      CC_NO_UNDO,    1'b0, S_END);
            S_UINN:  w = make_uword(OP_SET_UNDO, CC_TOP_LE_REF, 1'b0, S_UPOP);
            S_USRD:  w = make_uword(OP_RD_SWAP,  CC_NEVER,      1'b0, S_IDLE);
            S_USW1:  w = make_uword(OP_WR_A,     CC_NEVER,      1'b0, S_IDLE);
            S_USW2:  w = make_uword(OP_WR_B_DEC, CC_ALWAYS,     1'b0, S_UINN);
            S_UPOP:  w = make_uword(OP_POP,      CC_ALWAYS,     1'b0, S_UCHK);
            S_END:   w = make_uword(OP_END,      CC_ALWAYS,     1'b0, S_IDLE);
            S_EXOUT: w = make_uword(OP_EMIT_EXH, CC_ALWAYS,     1'b1, S_IDLE);
            default: w = make_uword(OP_NOP,      CC_ALWAYS,     1'b0, S_IDLE);
        endcase
        return w;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/perfect_pairing_enumerator.sv -----
// A request runs through accept, a check for a finished sequence, the advance of the top loop level,
// the forward swap, a refill of the loop levels, the half pair words (half = padded count / 2, at
// most 8), the undo of swaps and the pop of levels at the end of a loop; the microcode sequencer
// issues one control word per cycle, holding it while the output stalls, and the position store
// takes one write per cycle, so each swap costs a read and two writes. Each pair word is read from
// the store, then loaded into the output register, and the step holds while the receiver lags. An
// exhausted request goes from the check to the exhausted word. The store comes out of reset and
// restart already in identity order, with no clearing pass. A new request is taken in the cycle after
// the unwind that follows the last pair word, or straight after an exhausted word is loaded into the output register.
`default_nettype none

module perfect_pairing_enumerator import ppe_pkg::*; (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_valid,
    output logic                       o_ready,
    input  wire logic                  i_restart,
    output logic                       o_valid,
    input  wire logic                  i_ready,
    output logic      [IDX_W-1:0]      o_first_index,
    output logic      [IDX_W-1:0]      o_second_index,
    output logic                       o_unpaired,
    output logic                       o_last_pair,
    output logic                       o_finished,
    output logic                       o_exhausted,
    input  wire logic                  i_cfg_valid,
    output logic                       o_cfg_ready,
    input  wire logic [CFG_ADDR_W-1:0] i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_uword w_uw;
    t_cond  w_flags;
    logic [OP_W-1:0] w_op;

    logic [CNT_W-1:0]   r_cnt;
    logic [IDX_W-1:0]   r_start;
    logic [DEPTH_W-1:0] r_depth;
    logic               r_done;
    logic [POS_W-1:0]   r_stack [STK_DEPTH];
    logic               r_fin;
    logic [PAIR_W-1:0]  r_pi;
    logic [POS_W-1:0]   r_sa;
    logic [POS_W-1:0]   r_sb;

    logic               r_out_valid;
    logic [IDX_W-1:0]   r_first;
    logic [IDX_W-1:0]   r_second;
    logic               r_unp;
    logic               r_lastp;
    logic               r_fin_o;
    logic               r_exh;

    logic [PCNT_W-1:0]  w_c;
    logic [PCNT_W-1:0]  w_p;
    logic [DEPTH_W-1:0] w_half;
    logic [POS_W-1:0]   w_dummy;
    logic               w_odd;
    logic [DEPTH_W-1:0] w_depth_m1;
    logic [PAIR_W-1:0]  w_top;
    logic [POS_W-1:0]   w_top_val;
    logic [PCNT_W-1:0]  w_top_inc;
    logic [DEPTH_W:0]   w_ref_full;
    logic [POS_W-1:0]   w_ref;
    logic [DEPTH_W-1:0] w_pi_inc;
    logic               w_all_last;
    logic               w_out_busy;
    logic               w_accept;
    logic               w_clear;

    logic               w_rd_en;
    logic [POS_W-1:0]   w_rd_addr_a;
    logic [POS_W-1:0]   w_rd_addr_b;
    logic [POS_W-1:0]   w_rd_a;
    logic [POS_W-1:0]   w_rd_b;
    logic               w_wr_en;
    logic [POS_W-1:0]   w_wr_addr;
    logic [POS_W-1:0]   w_wr_data;
    logic [POS_W-1:0]   w_pa;
    logic [POS_W-1:0]   w_pb;
    logic               w_single;

    ppe_sequencer u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_flags (w_flags),
        .o_uword (w_uw)
    );

    ppe_pos_mem u_pos (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_clear     (w_clear),
        .i_rd_en     (w_rd_en),
        .i_rd_addr_a (w_rd_addr_a),
        .i_rd_addr_b (w_rd_addr_b),
        .o_rd_data_a (w_rd_a),
        .o_rd_data_b (w_rd_b),
        .i_wr_en     (w_wr_en),
        .i_wr_addr   (w_wr_addr),
        .i_wr_data   (w_wr_data)
    );

    // Effective count, padded size, pair count and dummy position
    always_comb begin
        if (r_cnt == '0) begin
            w_c = PCNT_W'(1);
        end else if (int'(r_cnt) > MAX_IDX) begin
            w_c = PCNT_W'(MAX_IDX);
        end else begin
            w_c = PCNT_W'(r_cnt);
        end
    end

    assign w_odd   = w_c[0];
    assign w_p     = w_c + PCNT_W'(w_odd);
    assign w_half  = DEPTH_W'(w_p >> 1);
    assign w_dummy = POS_W'(w_p - PCNT_W'(1));

    // Top of the loop stack and its reference position
    assign w_depth_m1 = r_depth - DEPTH_W'(1);
    assign w_top      = w_depth_m1[PAIR_W-1:0];
    assign w_top_val  = r_stack[w_top];
    assign w_top_inc  = PCNT_W'(w_top_val) + PCNT_W'(1);
    assign w_ref_full = {r_depth, 1'b0} - (DEPTH_W+1)'(1);
    assign w_ref      = w_ref_full[POS_W-1:0];
    assign w_pi_inc   = DEPTH_W'(r_pi) + DEPTH_W'(1);

    // Every live level at its last value: the undo will empty the stack
    always_comb begin
        w_all_last = 1'b1;
        for (int k = 0; k < STK_DEPTH; k++) begin
            if (DEPTH_W'(k) < r_depth && r_stack[k] != w_dummy) begin
                w_all_last = 1'b0;
            end
        end
    end

    assign w_out_busy = r_out_valid && !i_ready;

    always_comb begin
        w_flags.no_input   = !i_valid;
        w_flags.done       = r_done;
        w_flags.no_step    = !(r_depth != '0 && w_top_inc < w_p);
        w_flags.depth_lt   = r_depth < w_half;
        w_flags.more_pairs = w_pi_inc < w_half;
        w_flags.no_undo    = !(r_depth != '0 && w_top_inc == w_p);
        w_flags.top_le_ref = w_top_val <= w_ref;
        w_flags.out_busy   = w_out_busy;
    end

    // Drop the step's operation while it stalls on the output word
    assign w_op = (w_uw.hold_out && w_out_busy) ? OP_NOP : w_uw.op;

    assign o_ready     = (w_uw.op == OP_ACCEPT);
    assign o_cfg_ready = 1'b1;
    assign w_accept    = i_valid && (w_op == OP_ACCEPT);
    assign w_clear     = (w_accept && i_restart) ||
                         (i_cfg_valid && i_cfg_index == REG_INDEX_COUNT);

    // Position store ports
    assign w_rd_en     = (w_op == OP_RD_SWAP) || (w_op == OP_RD_PAIR);
    assign w_rd_addr_a = (w_op == OP_RD_PAIR) ? {r_pi, 1'b0} : r_sa;
    assign w_rd_addr_b = (w_op == OP_RD_PAIR) ? {r_pi, 1'b1} : r_sb;
    assign w_wr_en     = (w_op == OP_WR_A) || (w_op == OP_WR_B) || (w_op == OP_WR_B_DEC);
    assign w_wr_addr   = (w_op == OP_WR_A) ? r_sa : r_sb;
    assign w_wr_data   = (w_op == OP_WR_A) ? w_rd_b : w_rd_a;

    // Fold the dummy position into a lone index
    always_comb begin
        w_pa     = w_rd_a;
        w_pb     = w_rd_b;
        w_single = 1'b0;
        if (w_odd && w_rd_a == w_dummy) begin
            w_pa     = w_rd_b;
            w_single = 1'b1;
        end else if (w_odd && w_rd_b == w_dummy) begin
            w_pb     = w_rd_a;
            w_single = 1'b1;
        end
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt       <= CNT_W'(2);
            r_start     <= '0;
            r_depth     <= '0;
            r_done      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            // Rewind on a restart request or a new count
            if (w_clear) begin
                r_depth <= '0;
                r_done  <= 1'b0;
            end else begin
                case (w_op)
                    OP_FILL: begin
                        if (r_depth < w_half) begin
                            r_depth <= r_depth + DEPTH_W'(1);
                        end
                    end
                    OP_POP:  r_depth <= w_depth_m1;
                    OP_END:  r_done  <= (r_depth == '0);
                    default: ;
                endcase
            end

            if (w_op == OP_EMIT || w_op == OP_EMIT_EXH) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end

            if (i_cfg_valid) begin
                case (i_cfg_index)
                    REG_INDEX_COUNT: r_cnt   <= i_cfg_data[CNT_W-1:0];
                    REG_START_INDEX: r_start <= i_cfg_data[IDX_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    // Datapath payload
    always_ff @(posedge i_clk) begin
        case (w_op)
            OP_ADV: begin
                if (!w_flags.no_step) begin
                    r_stack[w_top] <= w_top_inc[POS_W-1:0];
                    r_sa           <= w_ref;
                    r_sb           <= w_top_inc[POS_W-1:0];
                end
            end
            OP_FILL: begin
                if (r_depth < w_half) begin
                    r_stack[r_depth[PAIR_W-1:0]] <= {r_depth[PAIR_W-1:0], 1'b1};
                end
            end
            OP_FIN: begin
                r_fin <= w_all_last;
                r_pi  <= '0;
            end
            OP_EMIT: begin
                r_first  <= r_start + IDX_W'(w_pa);
                r_second <= r_start + IDX_W'(w_pb);
                r_unp    <= w_single;
                r_lastp  <= (w_pi_inc == w_half);
                r_fin_o  <= r_fin;
                r_exh    <= 1'b0;
                r_pi     <= r_pi + PAIR_W'(1);
            end
            OP_SET_UNDO: begin
                r_sa <= w_ref;
                r_sb <= w_top_val;
            end
            OP_WR_B_DEC: r_stack[w_top] <= w_top_val - POS_W'(1);
            OP_EMIT_EXH: begin
                r_first  <= '0;
                r_second <= '0;
                r_unp    <= 1'b0;
                r_lastp  <= 1'b0;
                r_fin_o  <= 1'b0;
                r_exh    <= 1'b1;
            end
            default: ;
        endcase
    end

    assign o_valid        = r_out_valid;
    assign o_first_index  = r_first;
    assign o_second_index = r_second;
    assign o_unpaired     = r_unp;
    assign o_last_pair    = r_lastp;
    assign o_finished     = r_fin_o;
    assign o_exhausted    = r_exh;

endmodule

`default_nettype wire

// ----- rtl/ppe_pos_mem.sv -----
// Position order store: two registered read ports, one write port, identity until written.
`default_nettype none

module ppe_pos_mem import ppe_pkg::*; (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_clear,
    input  wire logic             i_rd_en,
    input  wire logic [POS_W-1:0] i_rd_addr_a,
    input  wire logic [POS_W-1:0] i_rd_addr_b,
    output logic      [POS_W-1:0] o_rd_data_a,
    output logic      [POS_W-1:0] o_rd_data_b,
    input  wire logic             i_wr_en,
    input  wire logic [POS_W-1:0] i_wr_addr,
    input  wire logic [POS_W-1:0] i_wr_data
);

    logic [POS_W-1:0]   r_mem [MAX_IDX];
    logic [MAX_IDX-1:0] r_valid;
    logic [POS_W-1:0]   r_rd_a;
    logic [POS_W-1:0]   r_rd_b;

    // An unwritten entry holds its own address
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clear) begin
            r_valid <= '0;
        end else if (i_wr_en) begin
            r_valid[i_wr_addr] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_a <= r_valid[i_rd_addr_a] ? r_mem[i_rd_addr_a] : i_rd_addr_a;
            r_rd_b <= r_valid[i_rd_addr_b] ? r_mem[i_rd_addr_b] : i_rd_addr_b;
        end
    end

    assign o_rd_data_a = r_rd_a;
    assign o_rd_data_b = r_rd_b;

endmodule

`default_nettype wire

// ----- rtl/ppe_sequencer.sv -----
// Microcode sequencer: step counter, control store lookup and conditional jumps.
`default_nettype none

module ppe_sequencer import ppe_pkg::*; (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire t_cond  i_flags,
    output t_uword      o_uword
);

    logic [PC_W-1:0] r_pc;
    logic [PC_W-1:0] n_pc;
    t_uword          w_uw;
    logic            w_taken;
    logic            w_stall;

    assign w_uw = ucode_rom(r_pc);

    always_comb begin
        case (w_uw.cond)
            CC_NEVER:      w_taken = 1'b0;
            CC_ALWAYS:     w_taken = 1'b1;
            CC_NO_INPUT:   w_taken = i_flags.no_input;
            CC_DONE:       w_taken = i_flags.done;
            CC_NO_STEP:    w_taken = i_flags.no_step;
            CC_DEPTH_LT:   w_taken = i_flags.depth_lt;
            CC_MORE_PAIRS: w_taken = i_flags.more_pairs;
            CC_NO_UNDO:    w_taken = i_flags.no_undo;
            CC_TOP_LE_REF: w_taken = i_flags.top_le_ref;
            default:       w_taken = 1'b0;
        endcase
    end

    // Hold the step while the output word is still waiting
    assign w_stall = w_uw.hold_out && i_flags.out_busy;

    always_comb begin
        if (w_stall) begin
            n_pc = r_pc;
        end else if (w_taken) begin
            n_pc = w_uw.target;
        end else begin
            n_pc = r_pc + PC_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc <= S_IDLE;
        end else begin
            r_pc <= n_pc;
        end
    end

    assign o_uword = w_uw;

endmodule

`default_nettype wire

// ----- rtl/ppe_checker.sv -----
// Port-level checker for the perfect pairing enumerator, bound to the top level.
`default_nettype none

module ppe_checker import ppe_pkg::*; (
    input wire logic                  i_clk,
    input wire logic                  i_rst_n,
    input wire logic                  i_valid,
    input wire logic                  o_ready,
    input wire logic                  o_valid,
    input wire logic                  i_ready,
    input wire logic [IDX_W-1:0]      o_first_index,
    input wire logic [IDX_W-1:0]      o_second_index,
    input wire logic                  o_unpaired,
    input wire logic                  o_last_pair,
    input wire logic                  o_finished,
    input wire logic                  o_exhausted
);

    // An exhausted word carries nothing else
    a_exh_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_exhausted |-> o_first_index == '0 && o_second_index == '0 &&
                                   !o_unpaired && !o_last_pair && !o_finished)
        else $error("exhausted word with non-zero fields");

    // A lone index repeats in both fields
    a_lone_equal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_unpaired |-> o_first_index == o_second_index && !o_exhausted)
        else $error("unpaired word with differing indices");

    // One request at a time: ready drops once a request is taken
    a_one_request: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready |=> !o_ready)
        else $error("second request taken back to back");

    // A stalled word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_first_index) &&
                                $stable(o_second_index) && $stable(o_last_pair))
        else $error("output word changed while stalled");

endmodule

bind perfect_pairing_enumerator ppe_checker u_ppe_checker (.*);

`default_nettype wire
